// File: hdl/cpp_lex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_lex_pkg: shared types and constants for the C preprocessing-token lexer
// Character codes, punctuator codes, lexer modes, the result record and the
// longest-match punctuator decoder.
// ----------------------------------------------------------------------------
package cpp_lex_pkg;

    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;

    // window: up to three held bytes plus the incoming one
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int HELD_MAX  = 3;

    localparam logic KIND_PUNCT = 1'b0;
    localparam logic KIND_OTHER = 1'b1;

    typedef enum logic [1:0] {
        LEX_BETWEEN   = 2'd0,
        LEX_LINE_CMT  = 2'd1,
        LEX_BLOCK_CMT = 2'd2,
        LEX_OTHER     = 2'd3
    } lex_mode_t;

    // characters
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_QUEST  = 8'h3F;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOT    = 8'h2E;

    // punctuator codes
    localparam logic [5:0] P_LBRACK     = 6'd0;
    localparam logic [5:0] P_RBRACK     = 6'd1;
    localparam logic [5:0] P_LPAREN     = 6'd2;
    localparam logic [5:0] P_RPAREN     = 6'd3;
    localparam logic [5:0] P_LBRACE     = 6'd4;
    localparam logic [5:0] P_RBRACE     = 6'd5;
    localparam logic [5:0] P_DOT        = 6'd6;
    localparam logic [5:0] P_ARROW      = 6'd7;
    localparam logic [5:0] P_INC        = 6'd8;
    localparam logic [5:0] P_DEC        = 6'd9;
    localparam logic [5:0] P_AMP        = 6'd10;
    localparam logic [5:0] P_STAR       = 6'd11;
    localparam logic [5:0] P_PLUS       = 6'd12;
    localparam logic [5:0] P_MINUS      = 6'd13;
    localparam logic [5:0] P_TILDE      = 6'd14;
    localparam logic [5:0] P_BANG       = 6'd15;
    localparam logic [5:0] P_SLASH      = 6'd16;
    localparam logic [5:0] P_PCT        = 6'd17;
    localparam logic [5:0] P_SHL        = 6'd18;
    localparam logic [5:0] P_SHR        = 6'd19;
    localparam logic [5:0] P_LT         = 6'd20;
    localparam logic [5:0] P_GT         = 6'd21;
    localparam logic [5:0] P_LE         = 6'd22;
    localparam logic [5:0] P_GE         = 6'd23;
    localparam logic [5:0] P_EQEQ       = 6'd24;
    localparam logic [5:0] P_NE         = 6'd25;
    localparam logic [5:0] P_CARET      = 6'd26;
    localparam logic [5:0] P_BAR        = 6'd27;
    localparam logic [5:0] P_ANDAND     = 6'd28;
    localparam logic [5:0] P_OROR       = 6'd29;
    localparam logic [5:0] P_QUEST      = 6'd30;
    localparam logic [5:0] P_COLON      = 6'd31;
    localparam logic [5:0] P_SEMI       = 6'd32;
    localparam logic [5:0] P_ELLIPSIS   = 6'd33;
    localparam logic [5:0] P_ASSIGN     = 6'd34;
    localparam logic [5:0] P_MUL_EQ     = 6'd35;
    localparam logic [5:0] P_DIV_EQ     = 6'd36;
    localparam logic [5:0] P_MOD_EQ     = 6'd37;
    localparam logic [5:0] P_ADD_EQ     = 6'd38;
    localparam logic [5:0] P_SUB_EQ     = 6'd39;
    localparam logic [5:0] P_SHL_EQ     = 6'd40;
    localparam logic [5:0] P_SHR_EQ     = 6'd41;
    localparam logic [5:0] P_AND_EQ     = 6'd42;
    localparam logic [5:0] P_XOR_EQ     = 6'd43;
    localparam logic [5:0] P_OR_EQ      = 6'd44;
    localparam logic [5:0] P_COMMA      = 6'd45;
    localparam logic [5:0] P_HASH       = 6'd46;
    localparam logic [5:0] P_HASHHASH   = 6'd47;
    localparam logic [5:0] P_DG_LBRACK  = 6'd48;
    localparam logic [5:0] P_DG_RBRACK  = 6'd49;
    localparam logic [5:0] P_DG_LBRACE  = 6'd50;
    localparam logic [5:0] P_DG_RBRACE  = 6'd51;
    localparam logic [5:0] P_DG_HASH    = 6'd52;
    localparam logic [5:0] P_DG_HASH2   = 6'd53;

    // one result, less the position fields
    typedef struct packed {
        logic       kind;
        logic [5:0] code;
        logic [7:0] text;
        logic       tok_first;
        logic       src_last;
    } lex_res_t;

    // need: lookahead byte not here yet; len 0: not a punctuator
    typedef struct packed {
        logic       need;
        logic [2:0] len;
        logic [5:0] code;
    } match_t;

    function automatic logic is_space(input logic [7:0] b);
        is_space = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NL) ||
                   (b == CH_VT) || (b == CH_FF) || (b == CH_CR);
    endfunction

    // longest match over b0..b3; avail counts the bytes present (1..4)
    function automatic match_t punct_match(input logic [7:0] b0, input logic [7:0] b1,
                                           input logic [7:0] b2, input logic [7:0] b3,
                                           input logic [2:0] avail, input logic fin);
        match_t m;
        logic   h1, h2, h3;
        logic   need1, need2, need3;
        logic   c1_eq, c1_gt, c1_lt, c1_colon, c1_pct, c1_dot;
        logic   c1_plus, c1_minus, c1_amp, c1_bar, c1_hash;
        logic   c2_eq, c2_dot, c2_pct, c3_colon;
        h1       = avail > 3'd1;
        h2       = avail > 3'd2;
        h3       = avail > 3'd3;
        need1    = !h1 && !fin;
        need2    = !h2 && !fin;
        need3    = !h3 && !fin;
        c1_eq    = h1 && (b1 == CH_EQ);
        c1_gt    = h1 && (b1 == CH_GT);
        c1_lt    = h1 && (b1 == CH_LT);
        c1_colon = h1 && (b1 == CH_COLON);
        c1_pct   = h1 && (b1 == CH_PCT);
        c1_dot   = h1 && (b1 == CH_DOT);
        c1_plus  = h1 && (b1 == CH_PLUS);
        c1_minus = h1 && (b1 == CH_MINUS);
        c1_amp   = h1 && (b1 == CH_AMP);
        c1_bar   = h1 && (b1 == CH_BAR);
        c1_hash  = h1 && (b1 == CH_HASH);
        c2_eq    = h2 && (b2 == CH_EQ);
        c2_dot   = h2 && (b2 == CH_DOT);
        c2_pct   = h2 && (b2 == CH_PCT);
        c3_colon = h3 && (b3 == CH_COLON);

        m.need = 1'b0;
        m.len  = 3'd1;
        m.code = P_LBRACK;
        case (b0)
            CH_LBRACK: m.code = P_LBRACK;
            CH_RBRACK: m.code = P_RBRACK;
            CH_LPAREN: m.code = P_LPAREN;
            CH_RPAREN: m.code = P_RPAREN;
            CH_LBRACE: m.code = P_LBRACE;
            CH_RBRACE: m.code = P_RBRACE;
            CH_TILDE:  m.code = P_TILDE;
            CH_QUEST:  m.code = P_QUEST;
            CH_SEMI:   m.code = P_SEMI;
            CH_COMMA:  m.code = P_COMMA;
            CH_STAR: begin
                m.need = need1;
                if (c1_eq) begin m.code = P_MUL_EQ; m.len = 3'd2; end
                else m.code = P_STAR;
            end
            CH_BANG: begin
                m.need = need1;
                if (c1_eq) begin m.code = P_NE; m.len = 3'd2; end
                else m.code = P_BANG;
            end
            CH_SLASH: begin
                m.need = need1;
                if (c1_eq) begin m.code = P_DIV_EQ; m.len = 3'd2; end
                else m.code = P_SLASH;
            end
            CH_EQ: begin
                m.need = need1;
                if (c1_eq) begin m.code = P_EQEQ; m.len = 3'd2; end
                else m.code = P_ASSIGN;
            end
            CH_CARET: begin
                m.need = need1;
                if (c1_eq) begin m.code = P_XOR_EQ; m.len = 3'd2; end
                else m.code = P_CARET;
            end
            CH_COLON: begin
                m.need = need1;
                if (c1_gt) begin m.code = P_DG_RBRACK; m.len = 3'd2; end
                else m.code = P_COLON;
            end
            CH_HASH: begin
                m.need = need1;
                if (c1_hash) begin m.code = P_HASHHASH; m.len = 3'd2; end
                else m.code = P_HASH;
            end
            CH_PLUS: begin
                m.need = need1;
                if (c1_plus) begin m.code = P_INC; m.len = 3'd2; end
                else if (c1_eq) begin m.code = P_ADD_EQ; m.len = 3'd2; end
                else m.code = P_PLUS;
            end
            CH_AMP: begin
                m.need = need1;
                if (c1_amp) begin m.code = P_ANDAND; m.len = 3'd2; end
                else if (c1_eq) begin m.code = P_AND_EQ; m.len = 3'd2; end
                else m.code = P_AMP;
            end
            CH_BAR: begin
                m.need = need1;
                if (c1_bar) begin m.code = P_OROR; m.len = 3'd2; end
                else if (c1_eq) begin m.code = P_OR_EQ; m.len = 3'd2; end
                else m.code = P_BAR;
            end
            CH_MINUS: begin
                m.need = need1;
                if (c1_minus) begin m.code = P_DEC; m.len = 3'd2; end
                else if (c1_eq) begin m.code = P_SUB_EQ; m.len = 3'd2; end
                else if (c1_gt) begin m.code = P_ARROW; m.len = 3'd2; end
                else m.code = P_MINUS;
            end
            CH_LT: begin
                if (need1) m.need = 1'b1;
                else if (c1_eq) begin m.code = P_LE; m.len = 3'd2; end
                else if (c1_colon) begin m.code = P_DG_LBRACK; m.len = 3'd2; end
                else if (c1_pct) begin m.code = P_DG_LBRACE; m.len = 3'd2; end
                else if (!c1_lt) m.code = P_LT;
                else if (need2) m.need = 1'b1;
                else if (c2_eq) begin m.code = P_SHL_EQ; m.len = 3'd3; end
                else begin m.code = P_SHL; m.len = 3'd2; end
            end
            CH_GT: begin
                if (need1) m.need = 1'b1;
                else if (c1_eq) begin m.code = P_GE; m.len = 3'd2; end
                else if (!c1_gt) m.code = P_GT;
                else if (need2) m.need = 1'b1;
                else if (c2_eq) begin m.code = P_SHR_EQ; m.len = 3'd3; end
                else begin m.code = P_SHR; m.len = 3'd2; end
            end
            CH_DOT: begin
                if (need1) m.need = 1'b1;
                else if (!c1_dot) m.code = P_DOT;
                else if (need2) m.need = 1'b1;
                else if (c2_dot) begin m.code = P_ELLIPSIS; m.len = 3'd3; end
                else m.code = P_DOT;
            end
            CH_PCT: begin
                if (need1) m.need = 1'b1;
                else if (c1_eq) begin m.code = P_MOD_EQ; m.len = 3'd2; end
                else if (c1_gt) begin m.code = P_DG_RBRACE; m.len = 3'd2; end
                else if (!c1_colon) m.code = P_PCT;
                else if (need2) m.need = 1'b1;
                else if (!c2_pct) begin m.code = P_DG_HASH; m.len = 3'd2; end
                else if (need3) m.need = 1'b1;
                else if (c3_colon) begin m.code = P_DG_HASH2; m.len = 3'd4; end
                else begin m.code = P_DG_HASH; m.len = 3'd2; end
            end
            default: m.len = 3'd0;
        endcase
        punct_match = m;
    endfunction

endpackage

// File: hdl/c_preprocessor_token_lexer.sv
`timescale 1ns / 1ps
// Path: a request accepted on s_ goes into the input register, then through the lexer step
//   into the result buffer once that is free; its first result then shows on m_.
// Throughput: one byte per cycle while each byte yields at most one result and m_ takes it;
//   a byte that yields several results holds the input side while the buffer drains.
// Reset: aresetn synchronous active low; clears the lexer to line 1, column 0, no held
//   bytes, and empties the input register and the result buffer.
// ----------------------------------------------------------------------------
// c_preprocessor_token_lexer: C punctuator and comment lexer, one byte per request
// Skips whitespace and comments, matches the 54 punctuators and digraphs by
// longest match, emits other bytes up to end of line, tracks line and column.
// ----------------------------------------------------------------------------
module c_preprocessor_token_lexer #(
    parameter int LINE_BITS   = cpp_lex_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = cpp_lex_pkg::COLUMN_BITS_DEF,
    parameter int M_DATA_W    = ((15 + LINE_BITS + COLUMN_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] src_byte
    input  logic                s_tlast,   // end_of_source
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // from bit 0: punct_code(6), text_byte(8), token_start(1),
    // line_number(LINE_BITS), column_number(COLUMN_BITS), zero fill
    output logic [M_DATA_W-1:0] m_tdata,
    output logic                m_tuser,   // token_kind
    output logic                m_tlast    // final_result
);
    import cpp_lex_pkg::*;

    localparam int DATA_BITS = 15 + LINE_BITS + COLUMN_BITS;

    // input register: holds one byte until the buffer can take its results
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_fin_reg;

    // result buffer, drained one entry per m_ request
    lex_res_t               buf_res_reg  [MAX_RES];
    logic [LINE_BITS-1:0]   buf_line_reg [MAX_RES];
    logic [COLUMN_BITS-1:0] buf_col_reg  [MAX_RES];
    logic [RES_CNT_W-1:0]   pend_reg;
    logic [RES_IDX_W-1:0]   rd_reg;

    lex_res_t               step_res  [MAX_RES];
    logic [LINE_BITS-1:0]   step_line [MAX_RES];
    logic [COLUMN_BITS-1:0] step_col  [MAX_RES];
    logic [RES_CNT_W-1:0]   step_cnt;

    logic                   buf_free;
    logic                   step;
    logic                   m_take;
    lex_res_t               out_res;
    logic [LINE_BITS-1:0]   out_line;
    logic [COLUMN_BITS-1:0] out_col;

    // the buffer is free when empty or once its last pending result leaves this cycle
    assign buf_free = (pend_reg == '0) || ((pend_reg == RES_CNT_W'(1)) && m_tready);
    assign step     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || step;
    assign m_take   = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_fin_reg  <= s_tlast;
        end
    end

    cpp_lex_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (step),
        .byte_i  (in_byte_reg),
        .fin_i   (in_fin_reg),
        .res_o   (step_res),
        .line_o  (step_line),
        .col_o   (step_col),
        .cnt_o   (step_cnt)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
            rd_reg   <= '0;
        end else if (step) begin
            pend_reg <= step_cnt;
            rd_reg   <= '0;
        end else if (m_take) begin
            pend_reg <= pend_reg - RES_CNT_W'(1);
            rd_reg   <= rd_reg + RES_IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            buf_res_reg  <= step_res;
            buf_line_reg <= step_line;
            buf_col_reg  <= step_col;
        end
    end

    assign out_res  = buf_res_reg[rd_reg];
    assign out_line = buf_line_reg[rd_reg];
    assign out_col  = buf_col_reg[rd_reg];

    assign m_tvalid = (pend_reg != '0);
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_res.src_last;
    assign m_tdata  = M_DATA_W'({out_col, out_line, out_res.tok_first,
                                 out_res.text, out_res.code});

    // the end-of-source mark only rides on the last result of its step
    a_last_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_take && m_tlast |-> pend_reg == RES_CNT_W'(1))
        else $error("final result taken with results still pending");

    a_line_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> out_line != '0)
        else $error("line number zero on a result");

    a_punct_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (out_res.kind == KIND_PUNCT) |-> out_res.text == 8'h00 && out_res.tok_first)
        else $error("punctuator result with text or without token start");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_fin_reg))
        else $error("input register lost a byte before its step");

    a_data_width: assert property (@(posedge aclk) disable iff (!aresetn)
        M_DATA_W >= DATA_BITS)
        else $error("result data port narrower than its fields");

endmodule

// File: hdl/cpp_lex_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpp_lex_core: lexer state and one-byte step
// Holds mode, held lookahead bytes and position; works the held bytes plus
// the new byte through up to four lexing steps and returns the results.
// ----------------------------------------------------------------------------
module cpp_lex_core #(
    parameter int LINE_BITS   = cpp_lex_pkg::LINE_BITS_DEF,
    parameter int COLUMN_BITS = cpp_lex_pkg::COLUMN_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           step_i,
    input  logic [7:0]                     byte_i,
    input  logic                           fin_i,
    output cpp_lex_pkg::lex_res_t          res_o  [cpp_lex_pkg::MAX_RES],
    output logic [LINE_BITS-1:0]           line_o [cpp_lex_pkg::MAX_RES],
    output logic [COLUMN_BITS-1:0]         col_o  [cpp_lex_pkg::MAX_RES],
    output logic [cpp_lex_pkg::RES_CNT_W-1:0] cnt_o
);
    import cpp_lex_pkg::*;

    localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] COL_ZERO = '0;

    lex_mode_t              mode_reg, mode_next;
    logic                   star_reg, star_next;
    logic [1:0]             held_cnt_reg, held_cnt_next;
    logic [7:0]             held_reg  [HELD_MAX];
    logic [7:0]             held_next [HELD_MAX];
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next;
    logic [COLUMN_BITS-1:0] scol_reg, scol_next;

    logic [7:0]             q [MAX_RES];
    logic [2:0]             n, pos, avail;
    logic [1:0]             idx;
    logic [7:0]             w0, w1, w2, w3;
    logic                   waiting, stop;
    logic [RES_CNT_W-1:0]   res_n;
    match_t                 mt;
    logic                   em_en;
    lex_res_t               em;
    logic [LINE_BITS-1:0]   em_line;
    logic [COLUMN_BITS-1:0] em_col;

    function automatic logic [COLUMN_BITS-1:0] col_add(input logic [COLUMN_BITS-1:0] c,
                                                       input logic [2:0] k);
        logic [COLUMN_BITS:0] s;
        s = {1'b0, c} + (COLUMN_BITS + 1)'(k);
        col_add = s[COLUMN_BITS] ? '1 : s[COLUMN_BITS-1:0];
    endfunction

    function automatic logic [LINE_BITS-1:0] line_inc(input logic [LINE_BITS-1:0] l);
        line_inc = (l == '1) ? l : l + LINE_ONE;
    endfunction

    always_comb begin
        mode_next  = mode_reg;
        star_next  = star_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        sline_next = sline_reg;
        scol_next  = scol_reg;

        for (int j = 0; j < MAX_RES; j++) begin
            if (j < int'(held_cnt_reg))       q[j] = held_reg[j % HELD_MAX];
            else if (j == int'(held_cnt_reg)) q[j] = byte_i;
            else                              q[j] = 8'h00;
            res_o[j]  = '0;
            line_o[j] = '0;
            col_o[j]  = '0;
        end
        n       = {1'b0, held_cnt_reg} + 3'd1;
        pos     = 3'd0;
        waiting = 1'b0;
        stop    = 1'b0;
        res_n   = '0;
        avail   = 3'd0;
        idx     = 2'd0;
        w0      = 8'h00;
        w1      = 8'h00;
        w2      = 8'h00;
        w3      = 8'h00;
        mt      = '0;
        em_en   = 1'b0;
        em      = '0;
        em_line = '0;
        em_col  = '0;

        // each pass consumes at least one byte or stops
        for (int it = 0; it < MAX_RES; it++) begin
            em_en = 1'b0;
            if (!stop && (pos < n)) begin
                avail = n - pos;
                idx   = pos[1:0];
                w0    = q[idx];
                w1    = q[idx + 2'd1];
                w2    = q[idx + 2'd2];
                w3    = q[idx + 2'd3];
                mt    = punct_match(w0, w1, w2, w3, avail, fin_i);
                em    = '0;
                case (mode_next)
                    LEX_LINE_CMT: begin
                        pos = pos + 3'd1;
                        if (w0 == CH_NL) begin
                            line_next = line_inc(line_next);
                            col_next  = COL_ZERO;
                            mode_next = LEX_BETWEEN;
                        end else begin
                            col_next = col_add(col_next, 3'd1);
                        end
                    end
                    LEX_BLOCK_CMT: begin
                        pos = pos + 3'd1;
                        if (star_next && (w0 == CH_SLASH)) begin
                            star_next = 1'b0;
                            col_next  = col_add(col_next, 3'd1);
                            mode_next = LEX_BETWEEN;
                        end else begin
                            star_next = (w0 == CH_STAR);
                            if (w0 == CH_NL) begin
                                line_next = line_inc(line_next);
                                col_next  = COL_ZERO;
                            end else begin
                                col_next = col_add(col_next, 3'd1);
                            end
                        end
                    end
                    LEX_OTHER: begin
                        pos = pos + 3'd1;
                        if (w0 == CH_NL) begin
                            // newline ends the token and is then skipped as space
                            mode_next = LEX_BETWEEN;
                            line_next = line_inc(line_next);
                            col_next  = COL_ZERO;
                        end else begin
                            em_en        = 1'b1;
                            em.kind      = KIND_OTHER;
                            em.text      = w0;
                            em_line      = sline_next;
                            em_col       = scol_next;
                            col_next     = col_add(col_next, 3'd1);
                        end
                    end
                    default: begin
                        if (is_space(w0)) begin
                            pos = pos + 3'd1;
                            if (w0 == CH_NL) begin
                                line_next = line_inc(line_next);
                                col_next  = COL_ZERO;
                            end else begin
                                col_next = col_add(col_next, 3'd1);
                            end
                        end else if ((w0 == CH_SLASH) && (avail == 3'd1) && !fin_i) begin
                            waiting = 1'b1;
                            stop    = 1'b1;
                        end else if ((w0 == CH_SLASH) && (avail > 3'd1) &&
                                     ((w1 == CH_SLASH) || (w1 == CH_STAR))) begin
                            pos       = pos + 3'd2;
                            col_next  = col_add(col_next, 3'd2);
                            star_next = 1'b0;
                            mode_next = (w1 == CH_SLASH) ? LEX_LINE_CMT : LEX_BLOCK_CMT;
                        end else if (mt.need) begin
                            waiting = 1'b1;
                            stop    = 1'b1;
                        end else if (mt.len != 3'd0) begin
                            em_en        = 1'b1;
                            em.kind      = KIND_PUNCT;
                            em.code      = mt.code;
                            em.tok_first = 1'b1;
                            em_line      = line_next;
                            em_col       = col_next;
                            pos          = pos + mt.len;
                            col_next     = col_add(col_next, mt.len);
                        end else begin
                            sline_next   = line_next;
                            scol_next    = col_next;
                            em_en        = 1'b1;
                            em.kind      = KIND_OTHER;
                            em.text      = w0;
                            em.tok_first = 1'b1;
                            em_line      = line_next;
                            em_col       = col_next;
                            pos          = pos + 3'd1;
                            col_next     = col_add(col_next, 3'd1);
                            mode_next    = LEX_OTHER;
                        end
                    end
                endcase
                if (em_en && (res_n < RES_CNT_W'(MAX_RES))) begin
                    res_o[res_n[RES_IDX_W-1:0]]  = em;
                    line_o[res_n[RES_IDX_W-1:0]] = em_line;
                    col_o[res_n[RES_IDX_W-1:0]]  = em_col;
                    res_n = res_n + RES_CNT_W'(1);
                end
            end
        end

        // leftover bytes wait for more lookahead
        idx = pos[1:0];
        for (int j = 0; j < HELD_MAX; j++) begin
            held_next[j] = q[idx + 2'(j)];
        end
        held_cnt_next = waiting ? 2'(n - pos) : 2'd0;

        if (fin_i) begin
            if (res_n != '0) res_o[2'(res_n - RES_CNT_W'(1))].src_last = 1'b1;
            mode_next     = LEX_BETWEEN;
            star_next     = 1'b0;
            held_cnt_next = 2'd0;
            line_next     = LINE_ONE;
            col_next      = COL_ZERO;
            sline_next    = LINE_ONE;
            scol_next     = COL_ZERO;
        end
        cnt_o = res_n;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= LEX_BETWEEN;
            star_reg     <= 1'b0;
            held_cnt_reg <= 2'd0;
            line_reg     <= LINE_ONE;
            col_reg      <= COL_ZERO;
            sline_reg    <= LINE_ONE;
            scol_reg     <= COL_ZERO;
        end else if (step_i) begin
            mode_reg     <= mode_next;
            star_reg     <= star_next;
            held_cnt_reg <= held_cnt_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            sline_reg    <= sline_next;
            scol_reg     <= scol_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_i) begin
            held_reg <= held_next;
        end
    end

endmodule

// File: bench/c_preprocessor_token_lexer_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_preprocessor_token_lexer_test: self-checking bench for the punctuator lexer
// Streams C source bytes into the lexer with random gaps and output stalls.
// Every accepted byte goes through a local lexer model that predicts the
// tokens it releases. Each token on the result side is compared field by
// field with the oldest prediction. The stimulus is a few directed sources
// and random token streams.
// ----------------------------------------------------------------------------
module c_preprocessor_token_lexer_test;
    import cpp_lex_pkg::*;

    localparam int LINE_W  = LINE_BITS_DEF;
    localparam int COL_W   = COLUMN_BITS_DEF;
    localparam int TOKEN_W = ((15 + LINE_W + COL_W + 7) / 8) * 8;

    // m_tdata layout, lowest bit first
    localparam int TEXT_LSB  = 6;
    localparam int FIRST_BIT = 14;
    localparam int LINE_LSB  = 15;
    localparam int COL_LSB   = 15 + LINE_W;

    localparam int unsigned LINE_MAX = (1 << LINE_W) - 1;
    localparam int unsigned COL_MAX  = (1 << COL_W) - 1;

    // punct_code carried by bytes of an other token
    localparam logic [5:0] NO_CODE = '0;

    // one byte for the input side; drain holds it back until nothing is owed
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } src_item_t;

    typedef struct packed {
        logic              kind;
        logic [5:0]        code;
        logic [7:0]        text;
        logic              first;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic              last;
    } token_t;

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TOKEN_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;

    c_preprocessor_token_lexer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // spellings indexed by punctuator code
    string punct_text [54] = '{
        "[", "]", "(", ")", "{", "}", ".", "->", "++", "--",
        "&", "*", "+", "-", "~", "!", "/", "%", "<<", ">>",
        "<", ">", "<=", ">=", "==", "!=", "^", "|", "&&", "||",
        "?", ":", ";", "...", "=", "*=", "/=", "%=", "+=", "-=",
        "<<=", ">>=", "&=", "^=", "|=", ",", "#", "##", "<:", ":>",
        "<%", "%>", "%:", "%:%:"
    };

    src_item_t   source_bytes [$];     // requests not yet offered
    logic [7:0]  src_buf [$];          // random source under construction
    token_t      predicted_tokens [$]; // tokens owed by the lexer, oldest first
    token_t      step_tokens [$];      // tokens released by the current byte

    // model state
    lex_mode_t   mode;
    logic [7:0]  held [3];
    int          held_n;
    int unsigned line_no, col_no, tok_line, tok_col;
    bit          star_seen;

    // bookkeeping; tokens_owed and bytes_taken move with nonblocking updates
    // so the driver and the end sequence see a stable value at each edge
    int          tokens_owed   = 0;
    int          bytes_taken   = 0;
    int          errors        = 0;
    int          results_seen  = 0;
    int          sources_built = 0;
    logic [53:0] codes_seen    = '0;
    logic [15:0] tick          = '0;
    logic        calm          = 1'b0;
    int          gap_left;
    int          stall_left;

    // quiet stretches on both sides, and no idling at all near the end
    wire send_idle_ok = !calm && (tick[6:5] != 2'b00);
    wire take_idle_ok = !calm && (tick[8:7] != 2'b01);

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        tick <= tick + 16'd1;
    end

    // ------------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------------
    task automatic lex_restart();
        mode      = LEX_BETWEEN;
        held_n    = 0;
        line_no   = 1;
        col_no    = 0;
        tok_line  = 1;
        tok_col   = 0;
        star_seen = 1'b0;
    endtask

    function automatic void bump_col(input int unsigned k);
        col_no = (col_no + k > COL_MAX) ? COL_MAX : col_no + k;
    endfunction

    function automatic void next_line();
        if (line_no < LINE_MAX) line_no++;
        col_no = 0;
    endfunction

    function automatic void add_token(input logic kind, input logic [5:0] code,
                                      input logic [7:0] text, input logic first,
                                      input int unsigned at_line, input int unsigned at_col);
        token_t tok;
        tok.kind  = kind;
        tok.code  = code;
        tok.text  = text;
        tok.first = first;
        tok.line  = at_line[LINE_W-1:0];
        tok.col   = at_col[COL_W-1:0];
        tok.last  = 1'b0;
        if (step_tokens.size() < MAX_RES) step_tokens.push_back(tok);
    endfunction

    // byte i of the window: 256 once the source has ended, -1 if not here yet
    function automatic int peek(input logic [3:0][7:0] w, input int n, input int i,
                                input bit fin);
        if (i < n) return int'(w[i]);
        return fin ? 256 : -1;
    endfunction

    // longest punctuator at w[0]: -1 needs more bytes, 0 none, else its length
    function automatic int punct_len(input logic [3:0][7:0] w, input int n, input bit fin,
                                     output logic [5:0] code);
        int c1, c2, c3;
        code = NO_CODE;
        case (w[0])
            CH_LBRACK: begin code = P_LBRACK; return 1; end
            CH_RBRACK: begin code = P_RBRACK; return 1; end
            CH_LPAREN: begin code = P_LPAREN; return 1; end
            CH_RPAREN: begin code = P_RPAREN; return 1; end
            CH_LBRACE: begin code = P_LBRACE; return 1; end
            CH_RBRACE: begin code = P_RBRACE; return 1; end
            CH_TILDE:  begin code = P_TILDE;  return 1; end
            CH_QUEST:  begin code = P_QUEST;  return 1; end
            CH_SEMI:   begin code = P_SEMI;   return 1; end
            CH_COMMA:  begin code = P_COMMA;  return 1; end
            CH_STAR, CH_BANG, CH_SLASH, CH_EQ, CH_CARET, CH_PLUS, CH_AMP, CH_BAR,
            CH_MINUS, CH_LT, CH_GT, CH_PCT, CH_COLON, CH_HASH, CH_DOT: ;
            default: return 0;
        endcase
        c1 = peek(w, n, 1, fin);
        c2 = peek(w, n, 2, fin);
        c3 = peek(w, n, 3, fin);
        if (c1 < 0) return -1;
        case (w[0])
            CH_STAR:  code = (c1 == CH_EQ) ? P_MUL_EQ : P_STAR;
            CH_BANG:  code = (c1 == CH_EQ) ? P_NE : P_BANG;
            CH_SLASH: code = (c1 == CH_EQ) ? P_DIV_EQ : P_SLASH;
            CH_EQ:    code = (c1 == CH_EQ) ? P_EQEQ : P_ASSIGN;
            CH_CARET: code = (c1 == CH_EQ) ? P_XOR_EQ : P_CARET;
            CH_COLON: code = (c1 == CH_GT) ? P_DG_RBRACK : P_COLON;
            CH_HASH:  code = (c1 == CH_HASH) ? P_HASHHASH : P_HASH;
            CH_PLUS:  code = (c1 == CH_PLUS) ? P_INC : (c1 == CH_EQ) ? P_ADD_EQ : P_PLUS;
            CH_AMP:   code = (c1 == CH_AMP) ? P_ANDAND : (c1 == CH_EQ) ? P_AND_EQ : P_AMP;
            CH_BAR:   code = (c1 == CH_BAR) ? P_OROR : (c1 == CH_EQ) ? P_OR_EQ : P_BAR;
            CH_MINUS: begin
                if (c1 == CH_MINUS) code = P_DEC;
                else if (c1 == CH_EQ) code = P_SUB_EQ;
                else if (c1 == CH_GT) code = P_ARROW;
                else code = P_MINUS;
            end
            CH_LT: begin
                if (c1 == CH_EQ) code = P_LE;
                else if (c1 == CH_COLON) code = P_DG_LBRACK;
                else if (c1 == CH_PCT) code = P_DG_LBRACE;
                else if (c1 != CH_LT) code = P_LT;
                else if (c2 < 0) return -1;
                else code = (c2 == CH_EQ) ? P_SHL_EQ : P_SHL;
            end
            CH_GT: begin
                if (c1 == CH_EQ) code = P_GE;
                else if (c1 != CH_GT) code = P_GT;
                else if (c2 < 0) return -1;
                else code = (c2 == CH_EQ) ? P_SHR_EQ : P_SHR;
            end
            CH_DOT: begin
                if (c1 != CH_DOT) code = P_DOT;
                else if (c2 < 0) return -1;
                else code = (c2 == CH_DOT) ? P_ELLIPSIS : P_DOT;
            end
            default: begin // percent sign
                if (c1 == CH_EQ) code = P_MOD_EQ;
                else if (c1 == CH_GT) code = P_DG_RBRACE;
                else if (c1 != CH_COLON) code = P_PCT;
                else if (c2 < 0) return -1;
                else if (c2 != CH_PCT) code = P_DG_HASH;
                else if (c3 < 0) return -1;
                else code = (c3 == CH_COLON) ? P_DG_HASH2 : P_DG_HASH;
            end
        endcase
        return punct_text[code].len();
    endfunction

    // one accepted request: lex held bytes plus the new one, queue the tokens
    task automatic lex_byte(input logic [7:0] in_byte, input logic fin);
        logic [3:0][7:0] q, w;
        logic [5:0]      code;
        logic [7:0]      c;
        int              n, pos, k, c1, i;
        bit              waiting;
        token_t          tok;
        q       = '0;
        n       = 0;
        pos     = 0;
        waiting = 1'b0;
        step_tokens.delete();
        for (i = 0; i < held_n; i++) begin
            q[n] = held[i];
            n++;
        end
        q[n] = in_byte;
        n++;

        while (pos < n) begin
            c = q[pos];
            case (mode)
                LEX_LINE_CMT: begin
                    pos++;
                    if (c == CH_NL) begin
                        next_line();
                        mode = LEX_BETWEEN;
                    end else bump_col(1);
                end
                LEX_BLOCK_CMT: begin
                    pos++;
                    if (star_seen && c == CH_SLASH) begin
                        star_seen = 1'b0;
                        bump_col(1);
                        mode = LEX_BETWEEN;
                    end else begin
                        star_seen = (c == CH_STAR);
                        if (c == CH_NL) next_line();
                        else bump_col(1);
                    end
                end
                LEX_OTHER: begin
                    // the newline ends the token and is then lexed as whitespace
                    if (c == CH_NL) mode = LEX_BETWEEN;
                    else begin
                        add_token(KIND_OTHER, NO_CODE, c, 1'b0, tok_line, tok_col);
                        pos++;
                        bump_col(1);
                    end
                end
                default: begin
                    w = q >> (8 * pos);
                    if (c == CH_SPACE || c == CH_TAB || c == CH_NL || c == CH_VT ||
                        c == CH_FF || c == CH_CR) begin
                        pos++;
                        if (c == CH_NL) next_line();
                        else bump_col(1);
                    end else begin
                        c1 = peek(w, n - pos, 1, fin);
                        if (c == CH_SLASH && c1 < 0) begin
                            waiting = 1'b1;
                            break;
                        end
                        if (c == CH_SLASH && (c1 == CH_SLASH || c1 == CH_STAR)) begin
                            pos += 2;
                            bump_col(2);
                            star_seen = 1'b0;
                            mode = (c1 == CH_SLASH) ? LEX_LINE_CMT : LEX_BLOCK_CMT;
                        end else begin
                            k = punct_len(w, n - pos, fin, code);
                            if (k < 0) begin
                                waiting = 1'b1;
                                break;
                            end
                            if (k > 0) begin
                                add_token(KIND_PUNCT, code, 8'h00, 1'b1, line_no, col_no);
                                pos += k;
                                bump_col(k);
                            end else begin
                                tok_line = line_no;
                                tok_col  = col_no;
                                add_token(KIND_OTHER, NO_CODE, c, 1'b1, tok_line, tok_col);
                                pos++;
                                bump_col(1);
                                mode = LEX_OTHER;
                            end
                        end
                    end
                end
            endcase
        end

        held_n = 0;
        if (waiting) begin
            for (i = 0; pos + i < n && i < HELD_MAX; i++) held[i] = q[pos + i];
            held_n = i;
        end

        if (fin && step_tokens.size() > 0) begin
            tok = step_tokens.pop_back();
            tok.last = 1'b1;
            step_tokens.push_back(tok);
        end
        foreach (step_tokens[j]) predicted_tokens.push_back(step_tokens[j]);
        if (fin) lex_restart();
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic put_byte(input logic [7:0] data, input logic last, input logic drain);
        src_item_t item;
        item.data  = data;
        item.last  = last;
        item.drain = drain;
        source_bytes.push_back(item);
        if (last) sources_built++;
    endtask

    task automatic put_text(input string s, input bit fin);
        for (int i = 0; i < s.len(); i++) put_byte(s[i], fin && i == s.len() - 1, 1'b0);
    endtask

    // ------------------------------------------------------------------------
    // driver: offers the next request once the current one is taken
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        src_item_t item;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end else begin
            calm <= source_bytes.size() < 80;
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (source_bytes.size() > 0 &&
                             (!source_bytes[0].drain || (!s_tvalid && tokens_owed == 0))) begin
                    item = source_bytes.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= item.data;
                    s_tlast  <= item.last;
                    // a gap starts once this request has been taken
                    if (send_idle_ok && $urandom_range(0, 5) == 0)
                        gap_left = $urandom_range(1, 7);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side backpressure: random stalls of m_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (take_idle_ok && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks tokens first, then predicts for the byte taken this edge
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        token_t want;
        if (!aresetn) begin
            lex_restart();
            tokens_owed <= 0;
            bytes_taken <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_tokens.size() == 0) begin
                    $display("%0t ns: unexpected token: expected none, %s %0b tlast %0b tdata %h",
                             $time, "got tuser", m_tuser, m_tlast, m_tdata);
                    errors++;
                end else begin
                    want = predicted_tokens.pop_front();
                    compare_field("token_kind", 32'(want.kind), 32'(m_tuser));
                    compare_field("punct_code", 32'(want.code), 32'(m_tdata[5:0]));
                    compare_field("text_byte", 32'(want.text), 32'(m_tdata[TEXT_LSB +: 8]));
                    compare_field("token_start", 32'(want.first), 32'(m_tdata[FIRST_BIT]));
                    compare_field("line_number", 32'(want.line),
                                  32'(m_tdata[LINE_LSB +: LINE_W]));
                    compare_field("column_number", 32'(want.col),
                                  32'(m_tdata[COL_LSB +: COL_W]));
                    compare_field("final_result", 32'(want.last), 32'(m_tlast));
                    results_seen++;
                    if (want.kind == KIND_PUNCT) codes_seen[want.code] = 1'b1;
                end
            end
            if (s_tvalid && s_tready) begin
                lex_byte(s_tdata, s_tlast);
                bytes_taken <= bytes_taken + 1;
            end
            tokens_owed <= predicted_tokens.size();
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        string      spelling;
        logic [7:0] b;
        int         total, random_count, budget, pick, spin, n_codes;
        bit         drain_next;

        // directed: a slash right after the opener does not close the comment;
        // an other token swallows comment markers and spaces up to the newline
        put_text("/*/*/a/* b\n", 1'b0);
        // byte extremes as an other token, then held lookahead flushed at end
        put_byte(8'hFF, 1'b0, 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
        put_text("\n<<=%:%", 1'b1);
        // unterminated block comment: dropped, no final mark
        put_text("/* ab", 1'b1);
        // lone slash at end of source
        put_text("/", 1'b1);

        // random sources built from fragments; adjacent punctuators re-lex
        random_count = 0;
        drain_next   = 1'b1;
        while (random_count < 440) begin
            src_buf.delete();
            budget = $urandom_range(4, 40);
            while (src_buf.size() < budget) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    spelling = punct_text[$urandom_range(0, 53)];
                    for (int j = 0; j < spelling.len(); j++) src_buf.push_back(spelling[j]);
                end else if (pick < 60) begin
                    case ($urandom_range(0, 5))
                        0: src_buf.push_back(CH_SPACE);
                        1: src_buf.push_back(CH_TAB);
                        2: src_buf.push_back(CH_NL);
                        3: src_buf.push_back(CH_VT);
                        4: src_buf.push_back(CH_FF);
                        default: src_buf.push_back(CH_CR);
                    endcase
                end else if (pick < 68) begin
                    src_buf.push_back(CH_SLASH);
                    src_buf.push_back(CH_SLASH);
                    repeat ($urandom_range(0, 8)) begin
                        b = 8'($urandom_range(0, 255));
                        src_buf.push_back(b == CH_NL ? CH_SPACE : b);
                    end
                    src_buf.push_back(CH_NL);
                end else if (pick < 76) begin
                    src_buf.push_back(CH_SLASH);
                    src_buf.push_back(CH_STAR);
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 3))
                            0: src_buf.push_back(CH_STAR);
                            1: src_buf.push_back(CH_SLASH);
                            2: src_buf.push_back(CH_NL);
                            default: src_buf.push_back(8'($urandom_range(0, 255)));
                        endcase
                    end
                    src_buf.push_back(CH_STAR);
                    src_buf.push_back(CH_SLASH);
                end else if (pick < 88) begin
                    // other token: a letter or a high byte, then anything but newline
                    b = ($urandom_range(0, 1) != 0) ? 8'h61 + 8'($urandom_range(0, 25))
                                                    : 8'h80 + 8'($urandom_range(0, 127));
                    src_buf.push_back(b);
                    repeat ($urandom_range(0, 8)) begin
                        b = 8'($urandom_range(0, 255));
                        src_buf.push_back(b == CH_NL ? CH_SPACE : b);
                    end
                    if ($urandom_range(0, 3) != 0) src_buf.push_back(CH_NL);
                end else begin
                    src_buf.push_back(8'($urandom_range(0, 255)));
                end
            end
            foreach (src_buf[i])
                put_byte(src_buf[i], i == src_buf.size() - 1, drain_next && i == 0);
            drain_next = 1'b0;
            random_count += src_buf.size();
        end

        total = source_bytes.size();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (bytes_taken < total) @(posedge aclk);
        for (spin = 0; spin < 4000 && tokens_owed != 0; spin++) @(posedge aclk);
        // room for any stray token still in the pipeline
        repeat (16) @(posedge aclk);
        if (tokens_owed != 0) begin
            $display("%0t ns: missing tokens: expected %0d more, got none", $time, tokens_owed);
            errors++;
        end

        n_codes = 0;
        for (int j = 0; j < 54; j++) if (codes_seen[j]) n_codes++;
        $display("Ran %0d source bytes in %0d sources: directed cases and random streams",
                 total, sources_built);
        $display("Checked %0d tokens; %0d of 54 punctuator codes seen", results_seen, n_codes);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, far above the slowest legal run
    initial begin
        #80_000_000;
        $display("Timeout: %0d of the source bytes taken, %0d tokens owed",
                 bytes_taken, tokens_owed);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
